// ----- sv/tsm_pkg.sv -----
`timescale 1ns / 1ps

package tsm_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic [1:0] CMD_PUSH_FIRST  = 2'd0;
    localparam logic [1:0] CMD_PUSH_SECOND = 2'd1;
    localparam logic [1:0] CMD_MERGE       = 2'd2;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;

    typedef logic [1:0] t_op_kind;

    localparam t_op_kind OP_PUSH_FIRST  = 2'd0;
    localparam t_op_kind OP_PUSH_SECOND = 2'd1;
    localparam t_op_kind OP_MERGE       = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      last_flag;
    } t_out_item;

    typedef struct packed {
        t_op_kind                  kind;
        logic signed [VALUE_W-1:0] value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_xfer;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/tsm_front.sv -----
`timescale 1ns / 1ps

module tsm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tsm_pkg::t_in_item  i_in_item,
    input  tsm_pkg::t_q_status i_q_status,
    output tsm_pkg::t_op_xfer  o_op
);
    import tsm_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_op      r_op;
    t_op      n_op;
    logic     accept;
    logic     known;
    t_op_kind kind;

    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        known = 1'b1;
        kind  = OP_MERGE;
        unique case (i_in_item.command)
            CMD_PUSH_FIRST:  kind = OP_PUSH_FIRST;
            CMD_PUSH_SECOND: kind = OP_PUSH_SECOND;
            CMD_MERGE:       kind = OP_MERGE;
            CMD_UNUSED:      known = 1'b0;
            default:         known = 1'b0;
        endcase
    end

    always_comb begin
        n_op = r_op;
        if (o_in_stall) begin
            n_valid = 1'b1;
        end else begin
            n_valid = accept && known;
            if (accept) begin
                n_op.kind  = kind;
                n_op.value = i_in_item.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op <= n_op;
    end

    assign o_op.valid = r_valid && !i_q_status.full;
    assign o_op.op    = r_op;

endmodule

// ----- sv/tsm_queue.sv -----
`timescale 1ns / 1ps

module tsm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsm_pkg::t_op_xfer  i_wr,
    output tsm_pkg::t_q_status o_status,
    output tsm_pkg::t_op_xfer  o_head,
    input  logic               i_pop
);
    import tsm_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] r_wptr;
    logic [QUEUE_AW:0] r_rptr;
    logic [QUEUE_AW:0] n_wptr;
    logic [QUEUE_AW:0] n_rptr;
    logic              do_wr;
    logic              do_rd;

    assign o_status.empty = (r_wptr == r_rptr);
    assign o_status.full  = (r_wptr[QUEUE_AW] != r_rptr[QUEUE_AW])
                         && (r_wptr[QUEUE_AW-1:0] == r_rptr[QUEUE_AW-1:0]);

    assign do_wr  = i_wr.valid && !o_status.full;
    assign do_rd  = i_pop && !o_status.empty;
    assign n_wptr = do_wr ? r_wptr + 1'b1 : r_wptr;
    assign n_rptr = do_rd ? r_rptr + 1'b1 : r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
        end
        if (do_wr) begin
            r_mem[r_wptr[QUEUE_AW-1:0]] <= i_wr.op;
        end
    end

    assign o_head.valid = !o_status.empty;
    assign o_head.op    = r_mem[r_rptr[QUEUE_AW-1:0]];

endmodule

// ----- sv/tsm_back.sv -----
`timescale 1ns / 1ps

module tsm_back #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsm_pkg::t_op_xfer  i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsm_pkg::t_out_item o_out_item
);
    import tsm_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic signed [VALUE_W-1:0] mem1 [STACK_DEPTH];
    logic signed [VALUE_W-1:0] mem2 [STACK_DEPTH];

    logic [CW-1:0]             r_cnt1;
    logic [CW-1:0]             r_cnt2;
    logic [CW-1:0]             n_cnt1;
    logic [CW-1:0]             n_cnt2;
    logic signed [VALUE_W-1:0] r_top1;
    logic signed [VALUE_W-1:0] r_top2;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_out_item                 r_out;
    t_out_item                 n_out;
    logic                      wr1;
    logic                      wr2;
    logic                      load_out;
    logic                      out_free;
    logic                      from_first;
    logic                      last;
    logic [CW:0]               total;
    logic [CW-1:0]             rd1_cnt;
    logic [CW-1:0]             rd2_cnt;
    logic [AW-1:0]             rd1;
    logic [AW-1:0]             rd2;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign total      = {1'b0, r_cnt1} + {1'b0, r_cnt2};
    assign last       = (total == (CW+1)'(1));
    assign from_first = (r_cnt2 == '0) || ((r_cnt1 != '0) && (r_top1 > r_top2));

    always_comb begin
        o_pop    = 1'b0;
        n_cnt1   = r_cnt1;
        n_cnt2   = r_cnt2;
        wr1      = 1'b0;
        wr2      = 1'b0;
        load_out = 1'b0;
        n_out    = r_out;
        if (i_head.valid) begin
            unique case (i_head.op.kind)
                OP_PUSH_FIRST: begin
                    o_pop = 1'b1;
                    if (r_cnt1 < CW'(STACK_DEPTH)) begin
                        wr1    = 1'b1;
                        n_cnt1 = r_cnt1 + 1'b1;
                    end
                end
                OP_PUSH_SECOND: begin
                    o_pop = 1'b1;
                    if (r_cnt2 < CW'(STACK_DEPTH)) begin
                        wr2    = 1'b1;
                        n_cnt2 = r_cnt2 + 1'b1;
                    end
                end
                OP_MERGE: begin
                    if (total == '0) begin
                        o_pop = 1'b1;
                    end else if (out_free) begin
                        load_out        = 1'b1;
                        o_pop           = last;
                        n_out.last_flag = last;
                        if (from_first) begin
                            n_cnt1             = r_cnt1 - 1'b1;
                            n_out.merged_value = r_top1;
                        end else begin
                            n_cnt2             = r_cnt2 - 1'b1;
                            n_out.merged_value = r_top2;
                        end
                    end
                end
                default: o_pop = 1'b1;
            endcase
        end
    end

    assign rd1_cnt     = n_cnt1 - 1'b1;
    assign rd2_cnt     = n_cnt2 - 1'b1;
    assign rd1         = rd1_cnt[AW-1:0];
    assign rd2         = rd2_cnt[AW-1:0];
    assign n_out_valid = load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (wr1) begin
            mem1[r_cnt1[AW-1:0]] <= i_head.op.value;
            r_top1               <= i_head.op.value;
        end else begin
            r_top1 <= mem1[rd1];
        end
        if (wr2) begin
            mem2[r_cnt2[AW-1:0]] <= i_head.op.value;
            r_top2               <= i_head.op.value;
        end else begin
            r_top2 <= mem2[rd2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt1      <= n_cnt1;
            r_cnt2      <= n_cnt2;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt1 <= CW'(STACK_DEPTH)) && (r_cnt2 <= CW'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (total != '0))
        else $error("result emitted from empty stacks");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && last) |=> ((r_cnt1 == '0) && (r_cnt2 == '0)))
        else $error("stacks not empty after last result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load_out)
        else $error("stalled result overwritten");

endmodule

// ----- sv/two_stack_merge_core.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_item  (command, value)
// out      output     o_out_valid / i_out_stall o_out_item (merged_value, last_flag)
//
// A merge of N stored elements gives N results, one result per cycle while the output
// is not stalled, set by the single top-of-stack read port per stack. A merge command
// passes through the front register, the queue and the output register before its
// first result. Reset is synchronous; no clearing pass is needed.
// A stalled output holds the merge; the queue absorbs up to four items before input stalls.

module two_stack_merge_core #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tsm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsm_pkg::t_out_item o_out_item
);
    import tsm_pkg::*;

    t_op_xfer  op_wr;
    t_op_xfer  head;
    t_q_status q_status;
    logic      pop;

    tsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_op       (op_wr)
    );

    tsm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (op_wr),
        .o_status (q_status),
        .o_head   (head),
        .i_pop    (pop)
    );

    tsm_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
